// ===== rtl/core/backlight_fade_idle_controller_defines.svh =====
// Assertion helpers shared by the controller's RTL files.
// They expect clk_i and rst_ni in the enclosing module.
`ifndef BACKLIGHT_FADE_IDLE_CONTROLLER_DEFINES_SVH
`define BACKLIGHT_FADE_IDLE_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bfic_pkg.sv =====
package bfic_pkg;

  // Field and state widths.
  localparam int DutyBits    = 9;
  localparam int TickBits    = 16;
  localparam int IdleBits    = 24;
  localparam int LevelBits   = 7;
  localparam int CmdBits     = 2;
  localparam int IdBits      = 11;
  localparam int LenBits     = 4;
  localparam int ByteBits    = 8;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 24;

  // Shared arithmetic unit widths. The quotient always fits in DutyBits.
  localparam int AccBits = DutyBits + TickBits;
  localparam int NumBits = AccBits + 1;
  localparam int DenBits = TickBits + 1;
  localparam int QuoBits = DutyBits;
  localparam int CntBits = $clog2(QuoBits + 1);

  // Command codes.
  localparam logic [CmdBits-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdBits-1:0] CMD_WAKE  = 2'd1;
  localparam logic [CmdBits-1:0] CMD_FRAME = 2'd2;
  localparam logic [CmdBits-1:0] CMD_NOP   = 2'd3;

  // Frame identifiers.
  localparam logic [IdBits-1:0] ID_MODE   = 11'h401;
  localparam logic [IdBits-1:0] ID_DAY    = 11'h412;
  localparam logic [IdBits-1:0] ID_NIGHT  = 11'h416;
  localparam logic [IdBits-1:0] ID_CAMERA = 11'h454;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_FADE_TICKS   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_IDLE_TIMEOUT = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_DUTY     = 2'd2;

  // Reset values.
  localparam logic [TickBits-1:0]  FadeTicksRst   = 16'd1000;
  localparam logic [IdleBits-1:0]  IdleTimeoutRst = 24'd10000;
  localparam logic [DutyBits-1:0]  MaxDutyRst     = {DutyBits{1'b1}};
  localparam logic [LevelBits-1:0] DayLevelRst    = 7'd80;
  localparam logic [LevelBits-1:0] NightLevelRst  = 7'd30;

  // Brightness mapping: 10..100 in, 5..80 percent out.
  localparam logic [ByteBits-1:0]  LevelInMin = 8'd10;
  localparam logic [ByteBits-1:0]  LevelInMax = 8'd100;
  localparam logic [LevelBits-1:0] LevelBase  = 7'd5;
  localparam int ScaleMul    = 75;
  localparam int ScaleDiv    = 90;
  localparam int PctDiv      = 100;
  localparam int PctRound    = 50;

  typedef enum logic [1:0] {
    ARITH_IDLE,
    ARITH_MUL,
    ARITH_MAC,
    ARITH_DIV
  } arith_op_e;

  // Request to the shared multiply and divide unit.
  typedef struct packed {
    arith_op_e            op;
    logic [TickBits-1:0]  mul_a;
    logic [DutyBits-1:0]  mul_b;
    logic [TickBits-1:0]  add_val;
    logic                 div_shl;
    logic [DenBits-1:0]   den;
  } arith_cmd_t;

  typedef struct packed {
    logic                busy;
    logic [QuoBits-1:0]  quo;
  } arith_sts_t;

  typedef struct packed {
    logic [CmdBits-1:0]  command;
    logic [IdBits-1:0]   frame_id;
    logic [LenBits-1:0]  frame_length;
    logic [ByteBits-1:0] byte_zero;
    logic [ByteBits-1:0] byte_one;
  } in_req_t;

  typedef struct packed {
    logic [DutyBits-1:0] duty;
    logic                fading;
    logic                night_active;
    logic                awake;
  } out_rsp_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0]  index;
    logic [CfgDataBits-1:0] value;
  } cfg_wr_t;

endpackage

// ===== rtl/core/bfic_if.sv =====
// Input request channel.
interface bfic_in_if;
  import bfic_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface bfic_out_if;
  import bfic_pkg::*;
  logic     valid;
  logic     ready;
  out_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface bfic_cfg_if;
  import bfic_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bfic_arith.sv =====
`include "backlight_fade_idle_controller_defines.svh"

module bfic_arith (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bfic_pkg::arith_cmd_t   cmd_i,
  output bfic_pkg::arith_sts_t   sts_o
);
  import bfic_pkg::*;

  logic [AccBits-1:0] acc_q, acc_d;
  logic [AccBits-1:0] prod;
  logic [NumBits-1:0] num;
  logic [DenBits-1:0] rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [QuoBits-1:0] bits_q, bits_d;
  logic [QuoBits-1:0] quo_q, quo_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits:0]   rem_sh;
  logic               ge;

  // One multiplier serves both products of the ramp and the level scaling.
  assign prod = AccBits'(cmd_i.mul_a) * AccBits'(cmd_i.mul_b);

  // Dividend for a new division, optionally doubled for rounding.
  assign num = (cmd_i.div_shl ? {acc_q, 1'b0} : {1'b0, acc_q}) + NumBits'(cmd_i.add_val);

  // Restoring division step: one quotient bit per cycle.
  assign rem_sh = {rem_q, bits_q[QuoBits-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    if (cnt_q != '0) begin
      rem_d  = ge ? DenBits'(rem_sh - {1'b0, den_q}) : rem_sh[DenBits-1:0];
      bits_d = {bits_q[QuoBits-2:0], 1'b0};
      quo_d  = {quo_q[QuoBits-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
    end else begin
      unique case (cmd_i.op)
        ARITH_MUL: acc_d = prod + AccBits'(cmd_i.add_val);
        ARITH_MAC: acc_d = acc_q + prod;
        ARITH_DIV: begin
          // The high part of the dividend is already below the divisor.
          rem_d  = num[NumBits-1:QuoBits];
          bits_d = num[QuoBits-1:0];
          den_d  = cmd_i.den;
          quo_d  = '0;
          cnt_d  = CntBits'(QuoBits);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
    quo_q  <= quo_d;
  end

  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.quo  = quo_q;

  `BFIC_ASSERT_IMP(div_idle_a, cmd_i.op != ARITH_IDLE, !sts_o.busy, "arith request while dividing")
  `BFIC_ASSERT_IMP(div_fit_a, cmd_i.op == ARITH_DIV, num[NumBits-1:QuoBits] < cmd_i.den, "too big")

endmodule

// ===== rtl/core/backlight_fade_idle_controller.sv =====
// Channel   Dir  Payload                                            Handshake
// in_i      in   command, frame_id, frame_length, byte_zero/one      valid/ready
// out_o     out  duty, fading, night_active, awake                   valid/ready
// cfg_i     in   index, value (fade, idle timeout, max duty)         valid/ready
//
// The block takes a new request only after the last one has left its output step. A tick
// that advances a ramp makes one pass through the shared arithmetic unit, whose divider
// yields one quotient bit per cycle. A brightness frame for the mode in use chains two
// passes; wake, camera, mode and other brightness frames take one pass. A tick without a
// ramp and any other request do not use the unit. Reset loads the register defaults
// directly. The sequencer holds in its output step while a result still waits.
`include "backlight_fade_idle_controller_defines.svh"

module backlight_fade_idle_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfic_in_if.sink     in_i,
  bfic_out_if.source  out_o,
  bfic_cfg_if.sink    cfg_i
);
  import bfic_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_MAC      = 3'd3;
  localparam logic [2:0] S_DIV_GO   = 3'd4;
  localparam logic [2:0] S_DIV_WAIT = 3'd5;
  localparam logic [2:0] S_CHECK    = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  // Computation in progress on the shared unit.
  localparam logic [1:0] K_RAMP        = 2'd0;
  localparam logic [1:0] K_LEVEL       = 2'd1;
  localparam logic [1:0] K_SCALE_DAY   = 2'd2;
  localparam logic [1:0] K_SCALE_NIGHT = 2'd3;

  logic [2:0]           state_q, state_d;
  logic [1:0]           kind_q, kind_d;
  in_req_t              req_q, req_d;
  logic [TickBits-1:0]  fade_ticks_q, fade_ticks_d;
  logic [IdleBits-1:0]  idle_timeout_q, idle_timeout_d;
  logic [DutyBits-1:0]  max_duty_q, max_duty_d;
  logic [DutyBits-1:0]  duty_q, duty_d;
  logic [DutyBits-1:0]  ramp_start_q, ramp_start_d;
  logic [DutyBits-1:0]  ramp_target_q, ramp_target_d;
  logic [TickBits-1:0]  ramp_elapsed_q, ramp_elapsed_d;
  logic                 ramp_active_q, ramp_active_d;
  logic [IdleBits-1:0]  idle_count_q, idle_count_d;
  logic [LevelBits-1:0] day_level_q, day_level_d;
  logic [LevelBits-1:0] night_level_q, night_level_d;
  logic                 night_flag_q, night_flag_d;
  logic                 out_valid_q, out_valid_d;
  out_rsp_t             out_data_q, out_data_d;

  arith_cmd_t           arith_cmd;
  arith_sts_t           arith_sts;

  logic [TickBits-1:0]  elapsed_inc;
  logic [IdleBits-1:0]  idle_inc;
  logic [ByteBits-1:0]  clamped;
  logic [LevelBits-1:0] scale_in;
  logic [LevelBits-1:0] mode_pct;
  logic [LevelBits-1:0] new_level;

  bfic_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (arith_cmd),
    .sts_o  (arith_sts)
  );

  // Saturating counters and brightness input clamp.
  assign elapsed_inc = (ramp_elapsed_q == '1) ? ramp_elapsed_q : ramp_elapsed_q + 1'b1;
  assign idle_inc    = (idle_count_q == '1) ? idle_count_q : idle_count_q + 1'b1;
  assign clamped     = (req_q.byte_zero < LevelInMin) ? LevelInMin :
                       (req_q.byte_zero > LevelInMax) ? LevelInMax : req_q.byte_zero;
  assign scale_in    = LevelBits'(clamped - LevelInMin);
  assign mode_pct    = night_flag_q ? night_level_q : day_level_q;
  assign new_level   = LevelBits'(arith_sts.quo) + LevelBase;

  // Operands for the shared unit, chosen by step and computation.
  always_comb begin
    arith_cmd = '0;
    arith_cmd.op = ARITH_IDLE;
    unique case (state_q)
      S_MUL: begin
        arith_cmd.op = ARITH_MUL;
        unique case (kind_q)
          K_RAMP: begin
            arith_cmd.mul_a = fade_ticks_q - ramp_elapsed_q;
            arith_cmd.mul_b = ramp_start_q;
          end
          K_LEVEL: begin
            arith_cmd.mul_a   = TickBits'(mode_pct);
            arith_cmd.mul_b   = max_duty_q;
            arith_cmd.add_val = TickBits'(PctRound);
          end
          default: begin
            arith_cmd.mul_a = TickBits'(scale_in);
            arith_cmd.mul_b = DutyBits'(ScaleMul);
          end
        endcase
      end
      S_MAC: begin
        arith_cmd.op    = ARITH_MAC;
        arith_cmd.mul_a = ramp_elapsed_q;
        arith_cmd.mul_b = ramp_target_q;
      end
      S_DIV_GO: begin
        arith_cmd.op = ARITH_DIV;
        unique case (kind_q)
          K_RAMP: begin
            arith_cmd.div_shl = 1'b1;
            arith_cmd.add_val = fade_ticks_q;
            arith_cmd.den     = {fade_ticks_q, 1'b0};
          end
          K_LEVEL: arith_cmd.den = DenBits'(PctDiv);
          default: arith_cmd.den = DenBits'(ScaleDiv);
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer and architectural state.
  always_comb begin
    state_d        = state_q;
    kind_d         = kind_q;
    req_d          = req_q;
    fade_ticks_d   = fade_ticks_q;
    idle_timeout_d = idle_timeout_q;
    max_duty_d     = max_duty_q;
    duty_d         = duty_q;
    ramp_start_d   = ramp_start_q;
    ramp_target_d  = ramp_target_q;
    ramp_elapsed_d = ramp_elapsed_q;
    ramp_active_d  = ramp_active_q;
    idle_count_d   = idle_count_q;
    day_level_d    = day_level_q;
    night_level_d  = night_level_q;
    night_flag_d   = night_flag_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;

    // Configuration writes.
    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_FADE_TICKS:   fade_ticks_d   = cfg_i.data.value[TickBits-1:0];
        CFG_IDLE_TIMEOUT: idle_timeout_d = cfg_i.data.value[IdleBits-1:0];
        CFG_MAX_DUTY:     max_duty_d     = cfg_i.data.value[DutyBits-1:0];
        default: ;
      endcase
    end

    // The output register empties when the result is taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          req_d   = in_i.data;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_OUT;
        unique case (req_q.command)
          CMD_TICK: begin
            idle_count_d = idle_inc;
            state_d      = S_CHECK;
            if (ramp_active_q) begin
              ramp_elapsed_d = elapsed_inc;
              if (elapsed_inc >= fade_ticks_q) begin
                duty_d        = ramp_target_q;
                ramp_active_d = 1'b0;
              end else begin
                kind_d  = K_RAMP;
                state_d = S_MUL;
              end
            end
          end
          CMD_WAKE: begin
            idle_count_d = '0;
            kind_d       = K_LEVEL;
            state_d      = S_MUL;
          end
          CMD_FRAME: begin
            unique case (req_q.frame_id)
              ID_CAMERA: begin
                idle_count_d = '0;
                kind_d       = K_LEVEL;
                state_d      = S_MUL;
              end
              ID_DAY: begin
                if (req_q.frame_length != '0) begin
                  kind_d  = K_SCALE_DAY;
                  state_d = S_MUL;
                end
              end
              ID_NIGHT: begin
                if (req_q.frame_length != '0) begin
                  kind_d  = K_SCALE_NIGHT;
                  state_d = S_MUL;
                end
              end
              ID_MODE: begin
                if (req_q.frame_length > LenBits'(1)) begin
                  night_flag_d = req_q.byte_one[0];
                  idle_count_d = '0;
                  kind_d       = K_LEVEL;
                  state_d      = S_MUL;
                end
              end
              default: ;
            endcase
          end
          CMD_NOP: ;
          default: ;
        endcase
      end
      S_MUL: begin
        state_d = (kind_q == K_RAMP) ? S_MAC : S_DIV_GO;
      end
      S_MAC: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!arith_sts.busy) begin
          unique case (kind_q)
            K_RAMP: begin
              duty_d  = arith_sts.quo;
              state_d = S_CHECK;
            end
            K_LEVEL: begin
              // Start a fade toward the mode brightness.
              ramp_start_d   = duty_q;
              ramp_target_d  = arith_sts.quo;
              ramp_elapsed_d = '0;
              ramp_active_d  = 1'b1;
              state_d        = S_OUT;
            end
            K_SCALE_DAY: begin
              day_level_d = new_level;
              state_d     = S_OUT;
              if (!night_flag_q) begin
                idle_count_d = '0;
                kind_d       = K_LEVEL;
                state_d      = S_MUL;
              end
            end
            default: begin
              night_level_d = new_level;
              state_d       = S_OUT;
              if (night_flag_q) begin
                idle_count_d = '0;
                kind_d       = K_LEVEL;
                state_d      = S_MUL;
              end
            end
          endcase
        end
      end
      S_CHECK: begin
        // Idle timeout expired: fade to dark unless already heading there.
        if ((idle_count_q > idle_timeout_q) && (ramp_target_q > DutyBits'(1))) begin
          ramp_start_d   = duty_q;
          ramp_target_d  = '0;
          ramp_elapsed_d = '0;
          ramp_active_d  = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d             = 1'b1;
          out_data_d.duty         = duty_q;
          out_data_d.fading       = ramp_active_q;
          out_data_d.night_active = night_flag_q;
          out_data_d.awake        = (idle_count_q <= idle_timeout_q);
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      kind_q         <= K_RAMP;
      fade_ticks_q   <= FadeTicksRst;
      idle_timeout_q <= IdleTimeoutRst;
      max_duty_q     <= MaxDutyRst;
      duty_q         <= '0;
      ramp_start_q   <= '0;
      ramp_target_q  <= '0;
      ramp_elapsed_q <= '0;
      ramp_active_q  <= 1'b0;
      idle_count_q   <= '1;
      day_level_q    <= DayLevelRst;
      night_level_q  <= NightLevelRst;
      night_flag_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      kind_q         <= kind_d;
      fade_ticks_q   <= fade_ticks_d;
      idle_timeout_q <= idle_timeout_d;
      max_duty_q     <= max_duty_d;
      duty_q         <= duty_d;
      ramp_start_q   <= ramp_start_d;
      ramp_target_q  <= ramp_target_d;
      ramp_elapsed_q <= ramp_elapsed_d;
      ramp_active_q  <= ramp_active_d;
      idle_count_q   <= idle_count_d;
      day_level_q    <= day_level_d;
      night_level_q  <= night_level_d;
      night_flag_q   <= night_flag_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `BFIC_ASSERT_NXT(accept_decode_a, in_i.valid && in_i.ready, state_q == S_DECODE, "not decoded")
  `BFIC_ASSERT_IMP(out_load_a, $rose(out_valid_q), $past(state_q) == S_OUT, "stray result")

endmodule

// ===== tb/tb_backlight_fade_idle_controller.sv =====
`timescale 1ns / 100ps

module tb_backlight_fade_idle_controller;
  import bfic_pkg::*;

  localparam logic [IdleBits-1:0] IdleSat    = {IdleBits{1'b1}};
  localparam logic [TickBits-1:0] ElapsedSat = {TickBits{1'b1}};
  localparam int unsigned BusyPct      = 27;
  localparam int unsigned SettleCycles = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bfic_in_if  in_if ();
  bfic_out_if out_if ();
  bfic_cfg_if cfg_if ();

  backlight_fade_idle_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Requests waiting to be offered and status words still owed by the block.
  in_req_t     pending_requests[$];
  out_rsp_t    expected_status[$];
  int unsigned idle_pct = BusyPct;
  int unsigned faults   = 0;

  // Shadow copy of the controller state and its registers.
  logic [DutyBits-1:0]  duty_lvl;
  logic [DutyBits-1:0]  ramp_from;
  logic [DutyBits-1:0]  ramp_to;
  logic [TickBits-1:0]  ramp_pos;
  logic                 ramp_on;
  logic [IdleBits-1:0]  quiet_ticks;
  logic [LevelBits-1:0] day_pct;
  logic [LevelBits-1:0] night_pct;
  logic                 night_on;
  logic [TickBits-1:0]  fade_len;
  logic [IdleBits-1:0]  idle_limit;
  logic [DutyBits-1:0]  full_duty;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Brightness byte to percent, clamped to the valid input span.
  function automatic logic [LevelBits-1:0] scaled_level(input logic [ByteBits-1:0] raw);
    int unsigned v;
    v = 32'(raw);
    if (v < LevelInMin) v = LevelInMin;
    if (v > LevelInMax) v = LevelInMax;
    return LevelBits'(LevelBase + (v - LevelInMin) * ScaleMul / ScaleDiv);
  endfunction

  function automatic void begin_ramp(input logic [DutyBits-1:0] target);
    ramp_from = duty_lvl;
    ramp_to   = target;
    ramp_pos  = '0;
    ramp_on   = 1'b1;
  endfunction

  // Activity clears the idle count and fades toward the brightness of the mode in use.
  function automatic void wake_to_mode();
    int unsigned pct;
    quiet_ticks = '0;
    pct = 32'(night_on ? night_pct : day_pct);
    begin_ramp(DutyBits'((2 * full_duty * pct + 100) / 200));
  endfunction

  // Applies one request to the shadow state and returns the status it reports.
  function automatic out_rsp_t advance_backlight(input in_req_t req);
    longint unsigned span;
    longint unsigned pos;
    longint unsigned blend;
    out_rsp_t        rsp;
    case (req.command)
      CMD_TICK: begin
        if (quiet_ticks != IdleSat) quiet_ticks++;
        if (ramp_on) begin
          if (ramp_pos != ElapsedSat) ramp_pos++;
          if (ramp_pos >= fade_len) begin
            duty_lvl = ramp_to;
            ramp_on  = 1'b0;
          end else begin
            // Linear blend of start and target, rounded half up.
            span     = 64'(fade_len);
            pos      = 64'(ramp_pos);
            blend    = ramp_from * (span - pos) + ramp_to * pos;
            duty_lvl = DutyBits'((2 * blend + span) / (2 * span));
          end
        end
        if (quiet_ticks > idle_limit && ramp_to > 1) begin_ramp('0);
      end
      CMD_WAKE: wake_to_mode();
      CMD_FRAME: begin
        if (req.frame_id == ID_CAMERA) begin
          wake_to_mode();
        end else if (req.frame_id == ID_DAY) begin
          if (req.frame_length > 0) begin
            day_pct = scaled_level(req.byte_zero);
            if (!night_on) wake_to_mode();
          end
        end else if (req.frame_id == ID_NIGHT) begin
          if (req.frame_length > 0) begin
            night_pct = scaled_level(req.byte_zero);
            if (night_on) wake_to_mode();
          end
        end else if (req.frame_id == ID_MODE) begin
          if (req.frame_length > 1) begin
            night_on = req.byte_one[0];
            wake_to_mode();
          end
        end
      end
      // A no-op only reports the current state.
      default: ;
    endcase
    rsp.duty         = duty_lvl;
    rsp.fading       = ramp_on;
    rsp.night_active = night_on;
    rsp.awake        = (quiet_ticks <= idle_limit);
    return rsp;
  endfunction

  function automatic in_req_t make_request(input logic [CmdBits-1:0] cmd,
                                           input logic [IdBits-1:0] id,
                                           input logic [LenBits-1:0] len,
                                           input logic [ByteBits-1:0] b0,
                                           input logic [ByteBits-1:0] b1);
    in_req_t r;
    r.command      = cmd;
    r.frame_id     = id;
    r.frame_length = len;
    r.byte_zero    = b0;
    r.byte_one     = b1;
    return r;
  endfunction

  // Mostly ticks with wake events and well-formed frames, plus a little noise.
  function automatic in_req_t random_request();
    in_req_t     r;
    int unsigned pick;
    r.command      = CMD_TICK;
    r.frame_id     = IdBits'($urandom_range(2047));
    r.frame_length = LenBits'($urandom_range(8));
    r.byte_zero    = ByteBits'($urandom_range(1) ? $urandom_range(255) : $urandom_range(110));
    r.byte_one     = ByteBits'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 62) begin
      r.command = CMD_TICK;
    end else if (pick < 70) begin
      r.command = CMD_WAKE;
    end else if (pick < 95) begin
      r.command      = CMD_FRAME;
      r.frame_length = LenBits'(($urandom_range(7) == 0) ? $urandom_range(1) :
                                                           $urandom_range(2, 8));
      case ($urandom_range(3))
        0:       r.frame_id = ID_DAY;
        1:       r.frame_id = ID_NIGHT;
        2:       r.frame_id = ID_MODE;
        default: r.frame_id = ID_CAMERA;
      endcase
    end else if (pick < 98) begin
      r.command = CMD_FRAME;
    end else begin
      r.command = CMD_NOP;
    end
    return r;
  endfunction

  // Request driver: offers queued requests and predicts each accepted one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_status.push_back(advance_backlight(in_if.data));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_requests.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted status with the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    out_rsp_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: status with no request: duty %0d fading %0b night %0b awake %0b",
                   $time, out_if.data.duty, out_if.data.fading, out_if.data.night_active,
                   out_if.data.awake);
          faults++;
        end else begin
          want = expected_status.pop_front();
          if (out_if.data.duty !== want.duty) begin
            $display("%0t: duty expected %0d, got %0d", $time, want.duty, out_if.data.duty);
            faults++;
          end
          if (out_if.data.fading !== want.fading) begin
            $display("%0t: fading expected %0b, got %0b", $time, want.fading,
                     out_if.data.fading);
            faults++;
          end
          if (out_if.data.night_active !== want.night_active) begin
            $display("%0t: night_active expected %0b, got %0b", $time, want.night_active,
                     out_if.data.night_active);
            faults++;
          end
          if (out_if.data.awake !== want.awake) begin
            $display("%0t: awake expected %0b, got %0b", $time, want.awake,
                     out_if.data.awake);
            faults++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_register(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= value[CfgDataBits-1:0];
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_FADE_TICKS:   fade_len   = value[TickBits-1:0];
      CFG_IDLE_TIMEOUT: idle_limit = value[IdleBits-1:0];
      CFG_MAX_DUTY:     full_duty  = value[DutyBits-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned fade, input int unsigned timeout,
                           input int unsigned full);
    write_register(CFG_FADE_TICKS, fade);
    write_register(CFG_IDLE_TIMEOUT, timeout);
    write_register(CFG_MAX_DUTY, full);
  endtask

  // Waits until every request is accepted and answered, then lets the block settle.
  task automatic drain();
    while (pending_requests.size() != 0 || in_if.valid || expected_status.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random requests in two bursts, with a full drain between them.
  task automatic run_phase(input int unsigned count, input int unsigned busy);
    int unsigned chunk;
    idle_pct = busy;
    chunk = $urandom_range(count / 4, 3 * count / 4);
    repeat (chunk) pending_requests.push_back(random_request());
    drain();
    repeat (count - chunk) pending_requests.push_back(random_request());
    drain();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;

    // Shadow state starts from the reset values.
    duty_lvl    = '0;
    ramp_from   = '0;
    ramp_to     = '0;
    ramp_pos    = '0;
    ramp_on     = 1'b0;
    quiet_ticks = IdleSat;
    day_pct     = DayLevelRst;
    night_pct   = NightLevelRst;
    night_on    = 1'b0;
    fade_len    = FadeTicksRst;
    idle_limit  = IdleTimeoutRst;
    full_duty   = MaxDutyRst;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed requests under the reset configuration.
    pending_requests.push_back(make_request(CMD_NOP, 11'h7ff, 4'd8, 8'hff, 8'hff));
    pending_requests.push_back(make_request(CMD_TICK, '0, '0, '0, '0));
    pending_requests.push_back(make_request(CMD_WAKE, '0, '0, '0, '0));
    pending_requests.push_back(make_request(CMD_TICK, '0, '0, '0, '0));
    // Short brightness frame is ignored.
    pending_requests.push_back(make_request(CMD_FRAME, ID_DAY, 4'd0, 8'hff, 8'h00));
    // Day brightness below and above the input span, then its exact ends.
    pending_requests.push_back(make_request(CMD_FRAME, ID_DAY, 4'd1, 8'd0, 8'h00));
    pending_requests.push_back(make_request(CMD_TICK, '0, '0, '0, '0));
    pending_requests.push_back(make_request(CMD_FRAME, ID_DAY, 4'd8, 8'd255, 8'h00));
    pending_requests.push_back(make_request(CMD_FRAME, ID_DAY, 4'd3, 8'd100, 8'h00));
    pending_requests.push_back(make_request(CMD_FRAME, ID_DAY, 4'd2, 8'd10, 8'h00));
    // Night level written while day mode is in use.
    pending_requests.push_back(make_request(CMD_FRAME, ID_NIGHT, 4'd1, 8'd10, 8'h00));
    // Mode frame too short, then a real switch to night.
    pending_requests.push_back(make_request(CMD_FRAME, ID_MODE, 4'd1, 8'h00, 8'h01));
    pending_requests.push_back(make_request(CMD_FRAME, ID_MODE, 4'd2, 8'h00, 8'h01));
    pending_requests.push_back(make_request(CMD_TICK, '0, '0, '0, '0));
    pending_requests.push_back(make_request(CMD_FRAME, ID_NIGHT, 4'd5, 8'd55, 8'h00));
    pending_requests.push_back(make_request(CMD_FRAME, ID_DAY, 4'd2, 8'd70, 8'h00));
    // Only bit 0 of the second byte selects the mode.
    pending_requests.push_back(make_request(CMD_FRAME, ID_MODE, 4'd7, 8'h00, 8'hfe));
    pending_requests.push_back(make_request(CMD_FRAME, ID_CAMERA, 4'd0, 8'h00, 8'h00));
    pending_requests.push_back(make_request(CMD_FRAME, 11'h000, 4'd8, 8'hff, 8'hff));
    pending_requests.push_back(make_request(CMD_FRAME, 11'h7ff, 4'd8, 8'hff, 8'hff));
    pending_requests.push_back(make_request(CMD_TICK, '0, '0, '0, '0));
    pending_requests.push_back(make_request(CMD_NOP, '0, '0, '0, '0));
    drain();

    // Smallest nonzero settings: one-tick fades, a one-tick timeout, lowest full-scale duty.
    configure(1, 1, 1);
    run_phase(150, BusyPct);

    // Largest settings: the saturated idle count never passes the timeout.
    configure(65535, 16777215, 511);
    run_phase(100, BusyPct);

    // Random settings, one phase with both sides always ready.
    for (int k = 0; k < 8; k++) begin
      configure(($urandom_range(3) == 0) ? $urandom_range(41, 400) : $urandom_range(1, 40),
                $urandom_range(1, 80), $urandom_range(1, 511));
      run_phase(150, (k == 3) ? 0 : BusyPct);
    end

    if (faults == 0) begin
      $display("tb_backlight_fade_idle_controller: clean");
    end else begin
      $display("tb_backlight_fade_idle_controller: errors");
    end
    $finish;
  end

  // Watchdog in case the block stops answering.
  initial begin
    #1_000_000;
    $display("tb_backlight_fade_idle_controller: errors");
    $finish;
  end

endmodule
